// ===== rtl/cdt_pkg.sv =====
package cdt_pkg;

  // year field width, legal range 12 to 20
  localparam int YEAR_WIDTH = 14;
  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};

  // year / 25 by reciprocal multiplication, exact for every year of YEAR_WIDTH bits
  localparam int DIV25_SHIFT = YEAR_WIDTH + 5;
  localparam logic [YEAR_WIDTH:0] DIV25_MAGIC =
    (YEAR_WIDTH+1)'(((64'd1 << DIV25_SHIFT) + 64'd24) / 64'd25);
  localparam int PROD_W = 2 * YEAR_WIDTH + 1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_DEC_LAST = 5'd31;
  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // days per month, indexed by month code, zero for codes that name no month
  localparam logic [4:0] MONTH_DAYS [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic [2:0] {
    OP_SET_DATE = 3'd0,
    OP_SET_TIME = 3'd1,
    OP_DAY_FWD  = 3'd2,
    OP_DAY_BACK = 3'd3,
    OP_COMPARE  = 3'd4
  } cdt_op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DATE   = 2'd1,
    ST_BAD_TIME   = 2'd2,
    ST_YEAR_RANGE = 2'd3
  } cdt_status_e;

  typedef struct packed {
    logic [2:0]            op;
    logic [5:0]            day;
    logic [3:0]            month;
    logic [YEAR_WIDTH-1:0] year;
    logic [4:0]            hour;
    logic [5:0]            minute;
  } cdt_in_t;

  typedef struct packed {
    cdt_status_e           status;
    logic                  earlier;
    logic [4:0]            cur_day;
    logic [3:0]            cur_month;
    logic [YEAR_WIDTH-1:0] cur_year;
    logic [4:0]            cur_hour;
    logic [5:0]            cur_minute;
  } cdt_out_t;

  typedef struct packed {
    logic [4:0]            day;
    logic [3:0]            month;
    logic [YEAR_WIDTH-1:0] year;
    logic [4:0]            hour;
    logic [5:0]            minute;
  } cdt_stamp_t;

  localparam cdt_stamp_t STAMP_RESET = '{
    day: 5'd1, month: 4'd1, year: YEAR_WIDTH'(1), hour: 5'd0, minute: 6'd0
  };

  // gregorian leap rule: divisible by 4 and not by 100, or divisible by 400
  function automatic logic cdt_is_leap(input logic [YEAR_WIDTH-1:0] y);
    logic [PROD_W-1:0]       prod;
    logic [YEAR_WIDTH-1:0]   q;
    logic [YEAR_WIDTH+4:0]   q_ext;
    logic [YEAR_WIDTH+4:0]   back;
    logic                    div4;
    logic                    div16;
    logic                    div25;
    prod  = PROD_W'(y) * PROD_W'(DIV25_MAGIC);
    q     = YEAR_WIDTH'(prod >> DIV25_SHIFT);
    q_ext = {5'd0, q};
    back  = (q_ext << 4) + (q_ext << 3) + q_ext;
    div25 = (back == {5'd0, y});
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    return (div4 && !div25) || (div16 && div25);
  endfunction

  function automatic logic [4:0] cdt_days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    n = MONTH_DAYS[m];
    if (m == MONTH_FEB && leap) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/cdt_in_reg.sv =====
module cdt_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  cdt_pkg::cdt_in_t word_i,
  input  logic            take_i,
  output logic            valid_o,
  output cdt_pkg::cdt_in_t word_o
);
  import cdt_pkg::*;

  logic    valid_q, valid_d;
  cdt_in_t word_q, word_d;

  // full and not drained this cycle
  assign stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (!stall_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        word_d = word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/cdt_calc.sv =====
module cdt_calc (
  input  cdt_pkg::cdt_stamp_t st_i,
  input  cdt_pkg::cdt_in_t    cmd_i,
  output cdt_pkg::cdt_stamp_t st_o,
  output cdt_pkg::cdt_out_t   res_o
);
  import cdt_pkg::*;

  logic        st_leap;
  logic        cmd_leap;
  logic [4:0]  st_dim;
  logic [4:0]  prev_dim;
  logic [4:0]  cmd_dim;
  logic [3:0]  prev_month;
  logic        month_ok;
  cdt_stamp_t  nxt;
  cdt_status_e status;
  logic        earlier;

  assign st_leap    = cdt_is_leap(st_i.year);
  assign cmd_leap   = cdt_is_leap(cmd_i.year);
  assign st_dim     = cdt_days_in(st_i.month, st_leap);
  assign prev_month = st_i.month - 4'd1;
  assign prev_dim   = cdt_days_in(prev_month, st_leap);
  assign cmd_dim    = cdt_days_in(cmd_i.month, cmd_leap);
  assign month_ok   = (cmd_i.month >= MONTH_JAN) && (cmd_i.month <= MONTH_DEC);

  always_comb begin
    nxt     = st_i;
    status  = ST_OK;
    earlier = 1'b0;
    unique case (cdt_op_e'(cmd_i.op))
      OP_SET_DATE: begin
        if (cmd_i.year == '0 || !month_ok || cmd_i.day == 6'd0 ||
            cmd_i.day > {1'b0, cmd_dim}) begin
          status = ST_BAD_DATE;
        end else begin
          nxt.day   = cmd_i.day[4:0];
          nxt.month = cmd_i.month;
          nxt.year  = cmd_i.year;
        end
      end
      OP_SET_TIME: begin
        if (cmd_i.hour > HOUR_MAX || cmd_i.minute > MINUTE_MAX) begin
          status = ST_BAD_TIME;
        end else begin
          nxt.hour   = cmd_i.hour;
          nxt.minute = cmd_i.minute;
        end
      end
      OP_DAY_FWD: begin
        priority if (st_i.day < st_dim) begin
          nxt.day = st_i.day + 5'd1;
        end else if (st_i.month < MONTH_DEC) begin
          nxt.day   = DAY_FIRST;
          nxt.month = st_i.month + 4'd1;
        end else if (st_i.year < YEAR_MAX) begin
          nxt.day   = DAY_FIRST;
          nxt.month = MONTH_JAN;
          nxt.year  = st_i.year + YEAR_WIDTH'(1);
        end else begin
          status = ST_YEAR_RANGE;
        end
      end
      OP_DAY_BACK: begin
        priority if (st_i.day > DAY_FIRST) begin
          nxt.day = st_i.day - 5'd1;
        end else if (st_i.month > MONTH_JAN) begin
          nxt.month = prev_month;
          nxt.day   = prev_dim;
        end else if (st_i.year > YEAR_WIDTH'(1)) begin
          nxt.year  = st_i.year - YEAR_WIDTH'(1);
          nxt.month = MONTH_DEC;
          nxt.day   = DAY_DEC_LAST;
        end else begin
          status = ST_YEAR_RANGE;
        end
      end
      OP_COMPARE: begin
        // fields concatenated most significant first give the lexicographic order
        earlier = {st_i.year, st_i.month, 1'b0, st_i.day, st_i.hour, st_i.minute} <
                  {cmd_i.year, cmd_i.month, cmd_i.day, cmd_i.hour, cmd_i.minute};
      end
      default: begin
      end
    endcase
  end

  assign st_o             = nxt;
  assign res_o.status     = status;
  assign res_o.earlier    = earlier;
  assign res_o.cur_day    = nxt.day;
  assign res_o.cur_month  = nxt.month;
  assign res_o.cur_year   = nxt.year;
  assign res_o.cur_hour   = nxt.hour;
  assign res_o.cur_minute = nxt.minute;

endmodule

// ===== rtl/calendar_date_time_register_unit.sv =====
// a word goes from the input register through the calendar logic into the
// result register; one word per cycle unless out_stall_i holds it full,
// set by the single calendar stage between the two registers
// reset: stored stamp goes to 1 january year 1, 00:00, and both the input
// and the result register come up empty
module calendar_date_time_register_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cdt_pkg::cdt_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cdt_pkg::cdt_out_t out_word_o
);
  import cdt_pkg::*;

  // input register outputs
  logic       cmd_valid;
  cdt_in_t    cmd_word;

  // calendar logic outputs
  cdt_stamp_t st_next;
  cdt_out_t   res;

  // stored stamp and result register
  cdt_stamp_t st_q, st_d;
  logic       out_valid_q, out_valid_d;
  cdt_out_t   out_word_q, out_word_d;

  // result register can take a word when empty or when being drained
  logic       out_ready;
  logic       take;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign take      = cmd_valid && out_ready;

  cdt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .word_i  (in_word_i),
    .take_i  (out_ready),
    .valid_o (cmd_valid),
    .word_o  (cmd_word)
  );

  // all calendar work happens here, on the stamp as it stands this cycle
  cdt_calc u_calc (
    .st_i  (st_q),
    .cmd_i (cmd_word),
    .st_o  (st_next),
    .res_o (res)
  );

  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_ready) begin
      out_valid_d = cmd_valid;
    end
    // stamp and result move together, so the next word sees the new stamp
    if (take) begin
      st_d       = st_next;
      out_word_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= STAMP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // stored stamp is always a legal calendar date and time
  a_stamp_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.day >= DAY_FIRST && st_q.month >= MONTH_JAN && st_q.month <= MONTH_DEC &&
    st_q.year != '0 && st_q.hour <= HOUR_MAX && st_q.minute <= MINUTE_MAX)
    else $error("stored stamp out of range");

  // the stamp only moves when a word goes into the result register
  a_stamp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(st_q))
    else $error("stamp changed without a word");

  // a rejected word leaves the stamp as it was
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && res.status != ST_OK |=> $stable(st_q))
    else $error("rejected word changed the stamp");

  // range error only at the first or the last day that can be held
  a_range_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.status == ST_YEAR_RANGE |->
      (out_word_q.cur_year == YEAR_MAX && out_word_q.cur_month == MONTH_DEC &&
       out_word_q.cur_day == DAY_DEC_LAST) ||
      (out_word_q.cur_year == YEAR_WIDTH'(1) && out_word_q.cur_month == MONTH_JAN &&
       out_word_q.cur_day == DAY_FIRST))
    else $error("range error away from the range ends");

endmodule
